/* rtl/core/hsvp_pkg.sv */
// shared types and constants for the hsv pixel pair to led pulse encoder
// no dependencies
package hsvp_pkg;

  // conversion constants
  localparam int unsigned SECTOR_DEG  = 60;
  localparam int unsigned FULL_SCALE  = 255;
  localparam int unsigned HUE_MAX     = 360;
  localparam int unsigned SPAN        = FULL_SCALE * SECTOR_DEG;     // 15300
  localparam int unsigned RECIP_SHIFT = 36;
  // floor(2^36 / 15300), quotient estimate is low by at most one
  localparam longint unsigned RECIP   = (64'd1 << RECIP_SHIFT) / SPAN;

  // input register plus the four conversion stages
  localparam int unsigned PIPE_LAT    = 5;

  // pulse sequencing
  localparam int unsigned PULSES      = 48;
  localparam int unsigned PCNT_W      = $clog2(PULSES);

  // queue between conversion and serializer
  localparam int unsigned QDEPTH      = 8;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic REG_ONE_BIT  = 1'b0;
  localparam logic REG_ZERO_BIT = 1'b1;

  typedef struct packed {
    logic [8:0] left_hue;
    logic [7:0] left_sat;
    logic [7:0] left_val;
    logic [8:0] right_hue;
    logic [7:0] right_sat;
    logic [7:0] right_val;
    logic       final_pair;
  } pair_in_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        pair_done;
    logic        frame_done;
  } pulse_out_t;

  // one color, stored in emission order green, red, blue
  typedef struct packed {
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
  } grb_t;

  // converted pair waiting for serialization
  typedef struct packed {
    grb_t left;
    grb_t right;
    logic final_pair;
  } pair_grb_t;

endpackage

/* rtl/core/hsv_pixel_pair_to_led_bit_pulses_top.sv */
// top level: converts hsv pixel pairs into led bit pulse compare words
// depends on hsvp_pkg, hsvp_front, hsvp_fifo, hsvp_back
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one request per pixel
//   pair: hue, saturation and value for the left and right string plus a
//   final_pair mark. out channel (out_valid/out_ready/out_data) gives 48
//   compare words per pair: green, red, blue, msb first, left word then
//   right word for each bit. pair_done marks the 48th word, frame_done
//   marks it too when the pair was the last of a frame.
//   cfg port (cfg_we/cfg_index/cfg_data) sets the one and zero bit compare
//   values; write it only while the block is idle.
// timing:
//   a request passes the input register, conversion pipe and queue before
//   its first word is registered; the serializer emits one word per cycle
//   while the receiver is ready. the front converts a pair every cycle and
//   runs ahead up to 8 pairs into the queue; a request is taken while a slot is free.
// reset: synchronous, clears the queue, the word counter and both
//   compare registers. a receiver stall holds the output word and
//   backs up the queue; the front stops taking requests once it fills.
module hsv_pixel_pair_to_led_bit_pulses_top
  import hsvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pair_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pulse_out_t  out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] one_bit_pulse;
  logic [15:0] zero_bit_pulse;
  logic        push;
  logic        pop;
  logic        empty;
  pair_grb_t   push_data;
  pair_grb_t   head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      one_bit_pulse  <= '0;
      zero_bit_pulse <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ONE_BIT:  one_bit_pulse  <= cfg_data;
        REG_ZERO_BIT: zero_bit_pulse <= cfg_data;
        default:      one_bit_pulse  <= one_bit_pulse;
      endcase
    end
  end

  hsvp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .pop       (pop),
    .push      (push),
    .push_data (push_data)
  );

  hsvp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  hsvp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .one_bit_pulse  (one_bit_pulse),
    .zero_bit_pulse (zero_bit_pulse),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

/* rtl/core/hsvp_convert.sv */
// four stage hsv to rgb conversion for one pixel, free running
// depends on hsvp_pkg
module hsvp_convert
  import hsvp_pkg::*;
(
  input  logic       clk,
  input  logic [8:0] hue,
  input  logic [7:0] sat,
  input  logic [7:0] val,
  output grb_t       color
);

  // sector and remainder from the clamped hue
  logic [8:0]  hue_clamp;
  logic [2:0]  sec_c;
  logic [8:0]  base_c;
  logic [5:0]  rem_c;

  always_comb begin
    hue_clamp = (hue > 9'(HUE_MAX)) ? 9'(HUE_MAX) : hue;
    if (hue_clamp >= 9'(5 * SECTOR_DEG)) begin
      sec_c = 3'd5;
    end else if (hue_clamp >= 9'(4 * SECTOR_DEG)) begin
      sec_c = 3'd4;
    end else if (hue_clamp >= 9'(3 * SECTOR_DEG)) begin
      sec_c = 3'd3;
    end else if (hue_clamp >= 9'(2 * SECTOR_DEG)) begin
      sec_c = 3'd2;
    end else if (hue_clamp >= 9'(SECTOR_DEG)) begin
      sec_c = 3'd1;
    end else begin
      sec_c = 3'd0;
    end
    base_c = 9'(sec_c) * 9'(SECTOR_DEG);
    rem_c  = 6'(hue_clamp - base_c);
  end

  // stage 1: saturation products
  logic [2:0]  sec1;
  logic        grey1;
  logic [7:0]  val1;
  logic [13:0] sq1;
  logic [13:0] st1;
  logic [15:0] pp1;

  always_ff @(posedge clk) begin
    sec1  <= sec_c;
    grey1 <= (sat == 8'd0);
    val1  <= val;
    sq1   <= 14'(sat) * 14'(rem_c);
    st1   <= 14'(sat) * 14'(6'(SECTOR_DEG) - rem_c);
    pp1   <= 16'(val) * 16'(8'(FULL_SCALE) - sat);
  end

  // stage 2: value products, p divided by 255
  logic [2:0]  sec2;
  logic        grey2;
  logic [7:0]  val2;
  logic [21:0] xq2;
  logic [21:0] xt2;
  logic [7:0]  p2;
  logic [16:0] pdiv;

  assign pdiv = 17'(pp1) + 17'(pp1[15:8]) + 17'd1;

  always_ff @(posedge clk) begin
    sec2  <= sec1;
    grey2 <= grey1;
    val2  <= val1;
    xq2   <= 22'(val1) * 22'(14'(SPAN) - sq1);
    xt2   <= 22'(val1) * 22'(14'(SPAN) - st1);
    p2    <= pdiv[15:8];
  end

  // stage 3: reciprocal multiply for the divide by 15300
  logic [2:0]  sec3;
  logic        grey3;
  logic [7:0]  val3;
  logic [7:0]  p3;
  logic [21:0] xq3;
  logic [21:0] xt3;
  logic [8:0]  qe3;
  logic [8:0]  te3;
  logic [44:0] qprod;
  logic [44:0] tprod;

  assign qprod = 45'(xq2) * 45'(RECIP);
  assign tprod = 45'(xt2) * 45'(RECIP);

  always_ff @(posedge clk) begin
    sec3  <= sec2;
    grey3 <= grey2;
    val3  <= val2;
    p3    <= p2;
    xq3   <= xq2;
    xt3   <= xt2;
    qe3   <= qprod[44:RECIP_SHIFT];
    te3   <= tprod[44:RECIP_SHIFT];
  end

  // stage 4: quotient correction and sector select
  logic [21:0] qrem;
  logic [21:0] trem;
  logic [7:0]  q_fix;
  logic [7:0]  t_fix;
  grb_t        color_c;

  always_comb begin
    qrem  = xq3 - 22'(qe3) * 22'(SPAN);
    trem  = xt3 - 22'(te3) * 22'(SPAN);
    q_fix = 8'(qe3 + ((qrem >= 22'(SPAN)) ? 9'd1 : 9'd0));
    t_fix = 8'(te3 + ((trem >= 22'(SPAN)) ? 9'd1 : 9'd0));
    case (sec3)
      3'd0:    color_c = '{g: t_fix, r: val3,  b: p3};
      3'd1:    color_c = '{g: val3,  r: q_fix, b: p3};
      3'd2:    color_c = '{g: val3,  r: p3,    b: t_fix};
      3'd3:    color_c = '{g: q_fix, r: p3,    b: val3};
      3'd4:    color_c = '{g: p3,    r: t_fix, b: val3};
      default: color_c = '{g: p3,    r: val3,  b: q_fix};
    endcase
    if (grey3) begin
      color_c = '{g: val3, r: val3, b: val3};
    end
  end

  always_ff @(posedge clk) begin
    color <= color_c;
  end

endmodule

/* rtl/core/hsvp_front.sv */
// front end: accepts pixel pairs, converts both pixels, pushes into the queue
// depends on hsvp_pkg and hsvp_convert
module hsvp_front
  import hsvp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pair_in_t  in_data,
  input  logic      pop,
  output logic      push,
  output pair_grb_t push_data
);

  pair_in_t            req;
  logic [PIPE_LAT-1:0] vld;
  logic [PIPE_LAT-1:0] fin;
  logic [QCNT_W-1:0]   reserved;
  logic                accept;
  grb_t                left_color;
  grb_t                right_color;

  // a queue slot is reserved for every request in flight
  assign in_ready = (reserved < QCNT_W'(QDEPTH));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved + QCNT_W'(accept) - QCNT_W'(pop);
    end
  end

  // input register and valid tracking through the conversion pipe
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    fin <= {fin[PIPE_LAT-2:0], in_data.final_pair};
  end

  hsvp_convert u_left (
    .clk   (clk),
    .hue   (req.left_hue),
    .sat   (req.left_sat),
    .val   (req.left_val),
    .color (left_color)
  );

  hsvp_convert u_right (
    .clk   (clk),
    .hue   (req.right_hue),
    .sat   (req.right_sat),
    .val   (req.right_val),
    .color (right_color)
  );

  assign push      = vld[PIPE_LAT-1];
  assign push_data = '{left: left_color, right: right_color, final_pair: fin[PIPE_LAT-1]};

  // reservation never exceeds the queue
  a_reserved_bound: assert property (@(posedge clk) disable iff (rst)
    reserved <= QCNT_W'(QDEPTH))
    else $error("reservation count above queue depth");

  // every push was reserved
  a_push_reserved: assert property (@(posedge clk) disable iff (rst)
    push |-> reserved != '0)
    else $error("push without reservation");

endmodule

/* rtl/core/hsvp_fifo.sv */
// queue of converted pixel pairs between front and back
// depends on hsvp_pkg
module hsvp_fifo
  import hsvp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pair_grb_t push_data,
  input  logic      pop,
  output logic      empty,
  output pair_grb_t head
);

  pair_grb_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCNT_W'(QDEPTH)) || pop)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue underflow");

endmodule

/* rtl/core/hsvp_back.sv */
// back end: serializes each converted pair into 48 pulse words
// depends on hsvp_pkg
module hsvp_back
  import hsvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  pair_grb_t   head,
  output logic        pop,
  input  logic [15:0] one_bit_pulse,
  input  logic [15:0] zero_bit_pulse,
  output logic        out_valid,
  input  logic        out_ready,
  output pulse_out_t  out_data
);

  logic [PCNT_W-1:0] cnt;
  logic              load;
  logic              last;
  logic              side;
  logic [4:0]        bitpos;
  logic [23:0]       stream;
  logic              bit_val;

  // word order: color-major, msb first, left before right
  assign load    = !out_valid || out_ready;
  assign last    = (cnt == PCNT_W'(PULSES - 1));
  assign side    = cnt[0];
  assign bitpos  = cnt[PCNT_W-1:1];
  assign stream  = side ? head.right : head.left;
  assign bit_val = stream[5'd23 - bitpos];
  assign pop     = load && !empty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        cnt <= last ? '0 : cnt + PCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_data.pulse_width <= bit_val ? one_bit_pulse : zero_bit_pulse;
      out_data.pair_done   <= last;
      out_data.frame_done  <= last && head.final_pair;
    end
  end

  // a pair in progress stays at the queue head
  a_active_head: assert property (@(posedge clk) disable iff (rst)
    cnt != '0 |-> !empty)
    else $error("serializer mid-pair with empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt < PCNT_W'(PULSES))
    else $error("word counter out of range");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// testbench for hsv_pixel_pair_to_led_bit_pulses_top: drives hsv pixel pair requests,
// predicts the 48 compare words of each pair and checks them against the output channel
// depends on hsvp_pkg and the top level rtl
module tb
  import hsvp_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 12;

  // colors that can be read off the conversion directly
  localparam grb_t BLACK    = '{g: 8'h00, r: 8'h00, b: 8'h00};
  localparam grb_t WHITE    = '{g: 8'hff, r: 8'hff, b: 8'hff};
  localparam grb_t GREY_MID = '{g: 8'h80, r: 8'h80, b: 8'h80};
  localparam grb_t RED      = '{g: 8'h00, r: 8'hff, b: 8'h00};
  localparam grb_t GREEN    = '{g: 8'hff, r: 8'h00, b: 8'h00};
  localparam grb_t BLUE     = '{g: 8'h00, r: 8'h00, b: 8'hff};
  localparam grb_t YELLOW   = '{g: 8'hff, r: 8'hff, b: 8'h00};
  localparam grb_t CYAN     = '{g: 8'hff, r: 8'h00, b: 8'hff};
  localparam grb_t MAGENTA  = '{g: 8'h00, r: 8'hff, b: 8'hff};

  typedef struct {
    pair_in_t req;
    bit       typed;
    grb_t     left_rgb;
    grb_t     right_rgb;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  pair_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  pulse_out_t  out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  logic [15:0] one_word;
  logic [15:0] zero_word;
  pulse_out_t  pulse_words_due[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatches;
  int unsigned words_seen;
  int unsigned cycle_count;
  bit          hold_req;
  bit          idle_on;

  hsv_pixel_pair_to_led_bit_pulses_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // six-sector hsv conversion with exact truncation
  function automatic grb_t hsv_color(logic [8:0] hue, logic [7:0] sat, logic [7:0] val);
    int unsigned h, s, v, sec, rem, p, q, t, span;
    grb_t c;
    span = FULL_SCALE * SECTOR_DEG;
    h = 32'(hue);
    s = 32'(sat);
    v = 32'(val);
    if (h > HUE_MAX) h = HUE_MAX;
    if (s == 0) begin
      c.r = 8'(v);
      c.g = 8'(v);
      c.b = 8'(v);
      return c;
    end
    // top of the hue range stays in the last sector
    if (h == HUE_MAX) begin
      sec = 5;
      rem = SECTOR_DEG;
    end else begin
      sec = h / SECTOR_DEG;
      rem = h - sec * SECTOR_DEG;
    end
    p = (v * (FULL_SCALE - s)) / FULL_SCALE;
    q = (v * (span - s * rem)) / span;
    t = (v * (span - s * (SECTOR_DEG - rem))) / span;
    case (sec)
      0: begin c.r = 8'(v); c.g = 8'(t); c.b = 8'(p); end
      1: begin c.r = 8'(q); c.g = 8'(v); c.b = 8'(p); end
      2: begin c.r = 8'(p); c.g = 8'(v); c.b = 8'(t); end
      3: begin c.r = 8'(p); c.g = 8'(q); c.b = 8'(v); end
      4: begin c.r = 8'(t); c.g = 8'(p); c.b = 8'(v); end
      default: begin c.r = 8'(v); c.g = 8'(p); c.b = 8'(q); end
    endcase
    return c;
  endfunction

  // expand one pair into its 48 compare words: g, r, b, msb first, left then right
  function automatic void predict_pair_words(pair_in_t req, grb_t lc, grb_t rc);
    logic [7:0] lcomp[3];
    logic [7:0] rcomp[3];
    pulse_out_t w;
    int unsigned n;
    logic bitval;
    lcomp = '{lc.g, lc.r, lc.b};
    rcomp = '{rc.g, rc.r, rc.b};
    n = 0;
    for (int c = 0; c < 3; c++) begin
      for (int k = 7; k >= 0; k--) begin
        for (int side = 0; side < 2; side++) begin
          bitval = side ? rcomp[c][k] : lcomp[c][k];
          w.pulse_width = bitval ? one_word : zero_word;
          w.pair_done = (n == PULSES - 1);
          w.frame_done = (n == PULSES - 1) && req.final_pair;
          pulse_words_due.push_back(w);
          n++;
        end
      end
    end
  endfunction

  function automatic pair_in_t mk_pair(int lh, int ls, int lv, int rh, int rs, int rv, bit fp);
    pair_in_t r;
    r.left_hue = 9'(lh);
    r.left_sat = 8'(ls);
    r.left_val = 8'(lv);
    r.right_hue = 9'(rh);
    r.right_sat = 8'(rs);
    r.right_val = 8'(rv);
    r.final_pair = fp;
    return r;
  endfunction

  function automatic void add_row(pair_in_t req, bit typed, grb_t lc, grb_t rc);
    dir_row_t row;
    row.req = req;
    row.typed = typed;
    row.left_rgb = lc;
    row.right_rgb = rc;
    dir_rows.push_back(row);
  endfunction

  // directed requests: grey, primaries, sector edges, hue above range, extremes
  function automatic void build_table();
    add_row(mk_pair(0, 0, 0, 0, 0, 0, 0), 1, BLACK, BLACK);
    add_row(mk_pair(0, 0, 255, 360, 0, 128, 0), 1, WHITE, GREY_MID);
    add_row(mk_pair(0, 255, 255, 360, 255, 255, 1), 1, RED, RED);
    add_row(mk_pair(120, 255, 255, 240, 255, 255, 0), 1, GREEN, BLUE);
    add_row(mk_pair(60, 255, 255, 180, 255, 255, 1), 1, YELLOW, CYAN);
    add_row(mk_pair(300, 255, 255, 511, 255, 255, 0), 1, MAGENTA, RED);
    add_row(mk_pair(361, 0, 255, 256, 0, 0, 1), 1, WHITE, BLACK);
    add_row(mk_pair(0, 255, 0, 200, 128, 0, 0), 1, BLACK, BLACK);
    add_row(mk_pair(59, 255, 255, 61, 255, 255, 0), 0, BLACK, BLACK);
    add_row(mk_pair(119, 200, 77, 121, 1, 255, 0), 0, BLACK, BLACK);
    add_row(mk_pair(179, 255, 170, 181, 128, 85, 1), 0, BLACK, BLACK);
    add_row(mk_pair(239, 85, 255, 241, 170, 200, 0), 0, BLACK, BLACK);
    add_row(mk_pair(299, 255, 1, 301, 254, 254, 0), 0, BLACK, BLACK);
    add_row(mk_pair(359, 255, 255, 360, 1, 255, 1), 0, BLACK, BLACK);
    add_row(mk_pair(256, 255, 255, 384, 100, 200, 0), 0, BLACK, BLACK);
    add_row(mk_pair(30, 128, 128, 90, 64, 192, 0), 0, BLACK, BLACK);
    add_row(mk_pair(150, 255, 128, 210, 192, 64, 1), 0, BLACK, BLACK);
    add_row(mk_pair(270, 37, 219, 330, 219, 37, 0), 0, BLACK, BLACK);
    add_row(mk_pair(1, 255, 255, 359, 1, 1, 0), 0, BLACK, BLACK);
    add_row(mk_pair(360, 128, 255, 0, 1, 255, 1), 0, BLACK, BLACK);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [8:0] rand_hue();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 9'($urandom_range(0, HUE_MAX));
    if (r < 8) return 9'(SECTOR_DEG * $urandom_range(0, 6));
    return 9'($urandom_range(0, 511));
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 1) return 8'h00;
    if (r < 2) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pair_in_t rand_pair();
    pair_in_t r;
    r.left_hue = rand_hue();
    r.left_sat = rand_byte();
    r.left_val = rand_byte();
    r.right_hue = rand_hue();
    r.right_sat = rand_byte();
    r.right_val = rand_byte();
    r.final_pair = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  // offer one request and record its words once it is taken
  task automatic send_pair(pair_in_t req, bit typed, grb_t lc, grb_t rc);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      predict_pair_words(req, lc, rc);
    end else begin
      predict_pair_words(req, hsv_color(req.left_hue, req.left_sat, req.left_val),
                         hsv_color(req.right_hue, req.right_sat, req.right_val));
    end
  endtask

  // called right at the accepting edge of the last request
  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pulse_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both compare registers, written back to back while idle
  task automatic set_pulses(logic [15:0] one_val, logic [15:0] zero_val);
    cfg_we <= 1'b1;
    cfg_index <= REG_ONE_BIT;
    cfg_data <= one_val;
    @(posedge clk);
    cfg_index <= REG_ZERO_BIT;
    cfg_data <= zero_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    one_word = one_val;
    zero_word = zero_val;
    @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin : ready_gen
    int unsigned run, stall;
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!idle_on) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 40);
        stall = pick_gap();
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // compare each accepted word with the oldest predicted one
  always @(posedge clk) begin : check_words
    pulse_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pulse_words_due.size() == 0) begin
        $display("%0t: unexpected word %h, none predicted", $time, out_data);
        mismatches++;
      end else begin
        want = pulse_words_due.pop_front();
        if (out_data.pulse_width !== want.pulse_width) begin
          $display("%0t: word %0d pulse_width expected %h, got %h", $time, words_seen,
                   want.pulse_width, out_data.pulse_width);
          mismatches++;
        end
        if (out_data.pair_done !== want.pair_done) begin
          $display("%0t: word %0d pair_done expected %b, got %b", $time, words_seen,
                   want.pair_done, out_data.pair_done);
          mismatches++;
        end
        if (out_data.frame_done !== want.frame_done) begin
          $display("%0t: word %0d frame_done expected %b, got %b", $time, words_seen,
                   want.frame_done, out_data.frame_done);
          mismatches++;
        end
      end
      words_seen++;
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ONE_BIT;
    cfg_data = '0;
    hold_req = 1'b0;
    idle_on = 1'b1;
    one_word = '0;
    zero_word = '0;
    mismatches = 0;
    words_seen = 0;
    cycle_count = 0;
    build_table();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first request runs on the reset compare values
    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (i == 1) begin
        stop_sending();
        wait_drain();
        set_pulses(16'hffff, 16'h0000);
      end
      send_pair(row.req, row.typed, row.left_rgb, row.right_rgb);
    end
    stop_sending();
    wait_drain();

    // random phases, each under its own compare values
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_pulses(16'h0000, 16'hffff);
        1: set_pulses(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        2: set_pulses(16'h8001, 16'h7ffe);
        default: set_pulses(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      idle_on = (p != 2);
      for (int n = 0; n < 28; n++) begin
        // long receiver hold-off so the queue fills and in_ready drops
        if (p == 1 && n == 4) hold_req = 1'b1;
        // sender pause until everything has come out
        if (p == 3 && n == 14) begin
          stop_sending();
          wait_drain();
        end
        send_pair(rand_pair(), 1'b0, BLACK, BLACK);
      end
      stop_sending();
      wait_drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
